/* sv/clns_pkg.sv */
// Shared types, codes and constants for the character LCD nibble sequencer.
// No dependencies; every other file imports this package.
package clns_pkg;

  localparam int unsigned WAIT_W     = 16;
  localparam int unsigned STEP_W     = 4;
  localparam int unsigned INIT_STEPS = 12;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [WAIT_W-1:0] INIT_WAIT_FIRST  = 16'd5000;
  localparam logic [WAIT_W-1:0] INIT_WAIT_SECOND = 16'd150;
  localparam logic [WAIT_W-1:0] INIT_FINAL_EXTRA = 16'd2000;
  localparam logic [WAIT_W-1:0] WAIT_MAX         = 16'hFFFF;

  localparam logic [7:0] CURSOR_BASE_ROW0 = 8'h80;
  localparam logic [7:0] CURSOR_BASE_ROW1 = 8'hC0;
  localparam logic [7:0] CLEAR_DISPLAY    = 8'h01;
  localparam logic [7:0] LCD_HOME         = 8'h02;

  localparam logic [WAIT_W-1:0] RST_SHORT_SETTLE = 16'd50;
  localparam logic [WAIT_W-1:0] RST_LONG_SETTLE  = 16'd2000;
  localparam logic [WAIT_W-1:0] RST_POWERUP_WAIT = 16'd20000;

  typedef enum logic [1:0] {
    CMD_COMMAND = 2'd0,
    CMD_DATA    = 2'd1,
    CMD_CURSOR  = 2'd2,
    CMD_INIT    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_ENABLE_PULSE = 2'd0,
    CFG_SHORT_SETTLE = 2'd1,
    CFG_LONG_SETTLE  = 2'd2,
    CFG_POWERUP_WAIT = 2'd3
  } cfg_idx_e;

  // One classified request as it sits in the queue.
  typedef struct packed {
    logic       init;
    logic       rs;
    logic [7:0] byte_val;
  } job_t;

  typedef struct packed {
    logic [WAIT_W-1:0] short_settle;
    logic [WAIT_W-1:0] long_settle;
    logic [WAIT_W-1:0] powerup_wait;
  } cfg_t;

  // Nibbles of the power-on sequence: 3,3,3,2 then 0x28, 0x0C, 0x06, 0x01.
  function automatic logic [3:0] init_nibble(input logic [STEP_W-1:0] step);
    logic [3:0] nib;
    case (step)
      4'd0, 4'd1, 4'd2: nib = 4'h3;
      4'd3, 4'd4:       nib = 4'h2;
      4'd5:             nib = 4'h8;
      4'd7:             nib = 4'hC;
      4'd9:             nib = 4'h6;
      4'd11:            nib = 4'h1;
      default:          nib = 4'h0;
    endcase
    return nib;
  endfunction

endpackage

/* sv/clns_front.sv */
// Front end: accepts requests, turns each into a queue entry, holds a short queue.
// Depends on clns_pkg.
module clns_front
  import clns_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] in_cmd_i,
  input  logic [7:0] in_byte_value_i,
  input  logic       in_row_i,
  input  logic [5:0] in_col_i,
  output logic       head_valid_o,
  output job_t       head_job_o,
  input  logic       pop_i
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             job_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  job_t             new_job;
  logic             push;
  logic             full;

  always_comb begin
    new_job = '0;
    case (cmd_e'(in_cmd_i))
      CMD_COMMAND: begin
        new_job.byte_val = in_byte_value_i;
      end
      CMD_DATA: begin
        new_job.rs       = 1'b1;
        new_job.byte_val = in_byte_value_i;
      end
      CMD_CURSOR: begin
        new_job.byte_val = (in_row_i ? CURSOR_BASE_ROW1 : CURSOR_BASE_ROW0)
                           + {2'b00, in_col_i};
      end
      CMD_INIT: begin
        new_job.init = 1'b1;
      end
      default: begin
        new_job = '0;
      end
    endcase
  end

  assign full         = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign in_stall_o   = full;
  assign push         = in_valid_i && !full;
  assign head_valid_o = (cnt_q != '0);
  assign head_job_o   = job_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push  ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + CNT_W'(push) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      job_q[wr_ptr_q] <= new_job;
    end
  end

endmodule

/* sv/clns_back.sv */
// Back end: steps through the queue head's words, one per cycle unless stalled.
// Depends on clns_pkg; reads the head entry of clns_front.
module clns_back
  import clns_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              head_valid_i,
  input  job_t              head_job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              out_reg_select_o,
  output logic [3:0]        out_nibble_o,
  output logic [WAIT_W-1:0] out_wait_before_us_o,
  output logic [WAIT_W-1:0] out_wait_after_us_o,
  output logic              out_last_o
);

  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              rs_q, rs_d;
  logic [3:0]        nib_q, nib_d;
  logic [WAIT_W-1:0] before_q, before_d;
  logic [WAIT_W-1:0] after_q, after_d;
  logic              last_q, last_d;
  logic              adv;
  logic              last_step;
  logic [WAIT_W-1:0] byte_settle;
  logic [WAIT_W:0]   final_sum;
  logic [WAIT_W-1:0] final_settle;

  assign adv       = head_valid_i && (!out_valid_q || !out_stall_i);
  assign last_step = head_job_i.init ? (step_q == STEP_W'(INIT_STEPS - 1))
                                     : step_q[0];
  assign pop_o     = adv && last_step;

  assign byte_settle = (!head_job_i.rs && (head_job_i.byte_val == CLEAR_DISPLAY ||
                        head_job_i.byte_val == LCD_HOME))
                       ? cfg_i.long_settle : cfg_i.short_settle;
  assign final_sum    = {1'b0, cfg_i.long_settle} + {1'b0, INIT_FINAL_EXTRA};
  assign final_settle = final_sum[WAIT_W] ? WAIT_MAX : final_sum[WAIT_W-1:0];

  always_comb begin
    rs_d     = head_job_i.rs;
    before_d = '0;
    after_d  = '0;
    last_d   = last_step;
    if (head_job_i.init) begin
      rs_d  = 1'b0;
      nib_d = init_nibble(step_q);
      if (step_q == '0) begin
        before_d = cfg_i.powerup_wait;
      end
      case (step_q)
        4'd0:              after_d = INIT_WAIT_FIRST;
        4'd1:              after_d = INIT_WAIT_SECOND;
        4'd5, 4'd7, 4'd9:  after_d = cfg_i.short_settle;
        4'd11:             after_d = final_settle;
        default:           after_d = '0;
      endcase
    end else begin
      // High nibble first; the settle goes on the low nibble.
      nib_d = step_q[0] ? head_job_i.byte_val[3:0] : head_job_i.byte_val[7:4];
      if (step_q[0]) begin
        after_d = byte_settle;
      end
    end
  end

  always_comb begin
    if (adv) begin
      step_d      = last_step ? '0 : step_q + 1'b1;
      out_valid_d = 1'b1;
    end else begin
      step_d      = step_q;
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rs_q     <= rs_d;
      nib_q    <= nib_d;
      before_q <= before_d;
      after_q  <= after_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_reg_select_o     = rs_q;
  assign out_nibble_o         = nib_q;
  assign out_wait_before_us_o = before_q;
  assign out_wait_after_us_o  = after_q;
  assign out_last_o           = last_q;

endmodule

/* sv/char_lcd_nibble_sequencer_unit.sv */
// Top level of the character LCD nibble sequencer: configuration registers,
// front end queue and back end stepper. Depends on clns_pkg, clns_front, clns_back.
//
// Each request becomes the 4-bit transfers of an HD44780-style bus, one word
// per transfer with RS, nibble, wait before and wait after. The back end emits
// one word per cycle from its step counter while the output is not stalled, so
// a command, data or cursor request becomes two words and an initialize request
// twelve. The front end accepts a request per cycle while its two-entry queue
// has room, and the output register accepts a new word in the same cycle the
// previous one is taken. The enable pulse width written at index 0 is not
// stored and does not affect any word produced here. Write configuration only
// while no request is in flight.
module char_lcd_nibble_sequencer_unit
  import clns_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [WAIT_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        in_cmd_i,
  input  logic [7:0]        in_byte_value_i,
  input  logic              in_row_i,
  input  logic [5:0]        in_col_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              out_reg_select_o,
  output logic [3:0]        out_nibble_o,
  output logic [WAIT_W-1:0] out_wait_before_us_o,
  output logic [WAIT_W-1:0] out_wait_after_us_o,
  output logic              out_last_o
);

  cfg_t cfg_q, cfg_d;
  logic head_valid;
  job_t head_job;
  logic pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ENABLE_PULSE: cfg_d = cfg_q;
        CFG_SHORT_SETTLE: cfg_d.short_settle = cfg_wdata_i;
        CFG_LONG_SETTLE:  cfg_d.long_settle  = cfg_wdata_i;
        CFG_POWERUP_WAIT: cfg_d.powerup_wait = cfg_wdata_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_settle <= RST_SHORT_SETTLE;
      cfg_q.long_settle  <= RST_LONG_SETTLE;
      cfg_q.powerup_wait <= RST_POWERUP_WAIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  clns_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_cmd_i        (in_cmd_i),
    .in_byte_value_i (in_byte_value_i),
    .in_row_i        (in_row_i),
    .in_col_i        (in_col_i),
    .head_valid_o    (head_valid),
    .head_job_o      (head_job),
    .pop_i           (pop)
  );

  clns_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg_q),
    .head_valid_i         (head_valid),
    .head_job_i           (head_job),
    .pop_o                (pop),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .out_reg_select_o     (out_reg_select_o),
    .out_nibble_o         (out_nibble_o),
    .out_wait_before_us_o (out_wait_before_us_o),
    .out_wait_after_us_o  (out_wait_after_us_o),
    .out_last_o           (out_last_o)
  );

endmodule

/* sv/clns_checker.sv */
// Port-level checks for the nibble sequencer, bound to the top level.
// Depends on clns_pkg and char_lcd_nibble_sequencer_unit.
module clns_checker
  import clns_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              out_reg_select_o,
  input logic [3:0]        out_nibble_o,
  input logic [WAIT_W-1:0] out_wait_before_us_o,
  input logic [WAIT_W-1:0] out_wait_after_us_o,
  input logic              out_last_o
);

  // Hold a stalled word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_nibble_o) &&
    $stable(out_reg_select_o) && $stable(out_last_o) &&
    $stable(out_wait_before_us_o) && $stable(out_wait_after_us_o))
    else $error("stalled output word changed");

  // Only the first init nibble carries a wait before.
  a_before_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_wait_before_us_o != '0 |->
    !out_reg_select_o && !out_last_o && out_nibble_o == 4'h3)
    else $error("wait before on a word other than the first init nibble");

  // A high data nibble has no settle time.
  a_data_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_reg_select_o && !out_last_o |-> out_wait_after_us_o == '0)
    else $error("settle time on the high nibble of a data byte");

  // A data word that ends a request follows its high nibble.
  a_data_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_reg_select_o && !out_last_o |=>
    out_valid_o && out_reg_select_o && out_last_o)
    else $error("data low nibble does not follow its high nibble");

endmodule

bind char_lcd_nibble_sequencer_unit clns_checker u_clns_checker (.*);

/* tb/tb_char_lcd_nibble_sequencer_unit.sv */
// Self-checking testbench for char_lcd_nibble_sequencer_unit: directed and random
// requests, expected transfer words predicted in the bench and checked in order.
// Depends on clns_pkg and the unit's RTL.
module tb_char_lcd_nibble_sequencer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import clns_pkg::*;

  localparam logic [7:0] FUNCTION_SET    = 8'h28;
  localparam logic [7:0] DISPLAY_ON      = 8'h0C;
  localparam logic [7:0] ENTRY_MODE      = 8'h06;
  localparam logic [3:0] WAKE_NIBBLE     = 4'h3;
  localparam logic [3:0] FOUR_BIT_NIBBLE = 4'h2;

  localparam int DIRECTED_ROWS   = 20;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 27;
  localparam int REPORT_LIMIT    = 50;
  localparam int SETTLE_CYCLES   = 16;

  typedef struct packed {
    logic              rs;
    logic [3:0]        nib;
    logic [WAIT_W-1:0] wait_pre;
    logic [WAIT_W-1:0] after;
    logic              last;
  } lcd_word_t;

  // Rows with typed set carry their result by hand: high nibble, low nibble, settle.
  typedef struct packed {
    cmd_e              cmd;
    logic [7:0]        bval;
    logic              lcd_row;
    logic [5:0]        lcd_col;
    logic              typed;
    logic              t_rs;
    logic [3:0]        t_hi;
    logic [3:0]        t_lo;
    logic [WAIT_W-1:0] t_settle;
  } dir_row_t;

  localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{CMD_INIT,    8'h00, 1'b0, 6'd0,  1'b0, 1'b0, 4'h0, 4'h0, 16'd0},
    '{CMD_COMMAND, 8'h01, 1'b0, 6'd0,  1'b1, 1'b0, 4'h0, 4'h1, 16'd2000},
    '{CMD_COMMAND, 8'h02, 1'b0, 6'd0,  1'b1, 1'b0, 4'h0, 4'h2, 16'd2000},
    '{CMD_COMMAND, 8'h00, 1'b0, 6'd0,  1'b1, 1'b0, 4'h0, 4'h0, 16'd50},
    '{CMD_COMMAND, 8'hFF, 1'b0, 6'd0,  1'b1, 1'b0, 4'hF, 4'hF, 16'd50},
    '{CMD_COMMAND, 8'h03, 1'b0, 6'd0,  1'b1, 1'b0, 4'h0, 4'h3, 16'd50},
    '{CMD_DATA,    8'h01, 1'b0, 6'd0,  1'b1, 1'b1, 4'h0, 4'h1, 16'd50},
    '{CMD_DATA,    8'h02, 1'b0, 6'd0,  1'b1, 1'b1, 4'h0, 4'h2, 16'd50},
    '{CMD_DATA,    8'h00, 1'b0, 6'd0,  1'b1, 1'b1, 4'h0, 4'h0, 16'd50},
    '{CMD_DATA,    8'hFF, 1'b0, 6'd0,  1'b1, 1'b1, 4'hF, 4'hF, 16'd50},
    '{CMD_CURSOR,  8'h00, 1'b0, 6'd0,  1'b1, 1'b0, 4'h8, 4'h0, 16'd50},
    '{CMD_CURSOR,  8'h00, 1'b1, 6'd0,  1'b1, 1'b0, 4'hC, 4'h0, 16'd50},
    '{CMD_CURSOR,  8'h00, 1'b0, 6'd39, 1'b1, 1'b0, 4'hA, 4'h7, 16'd50},
    '{CMD_CURSOR,  8'h00, 1'b1, 6'd39, 1'b1, 1'b0, 4'hE, 4'h7, 16'd50},
    '{CMD_CURSOR,  8'h00, 1'b1, 6'd63, 1'b1, 1'b0, 4'hF, 4'hF, 16'd50},
    '{CMD_CURSOR,  8'h00, 1'b0, 6'd63, 1'b1, 1'b0, 4'hB, 4'hF, 16'd50},
    '{CMD_CURSOR,  8'h01, 1'b1, 6'd42, 1'b0, 1'b0, 4'h0, 4'h0, 16'd0},
    '{CMD_COMMAND, 8'h5A, 1'b1, 6'd63, 1'b0, 1'b0, 4'h0, 4'h0, 16'd0},
    '{CMD_DATA,    8'hA5, 1'b1, 6'd21, 1'b0, 1'b0, 4'h0, 4'h0, 16'd0},
    '{CMD_INIT,    8'hFF, 1'b1, 6'd63, 1'b0, 1'b0, 4'h0, 4'h0, 16'd0}
  };

  logic              clk_i;
  logic              rst_ni          = 1'b0;
  logic              cfg_we_i        = 1'b0;
  logic [1:0]        cfg_idx_i       = '0;
  logic [WAIT_W-1:0] cfg_wdata_i     = '0;
  logic              in_valid_i      = 1'b0;
  logic              in_stall_o;
  logic [1:0]        in_cmd_i        = '0;
  logic [7:0]        in_byte_value_i = '0;
  logic              in_row_i        = 1'b0;
  logic [5:0]        in_col_i        = '0;
  logic              out_valid_o;
  logic              out_stall_i     = 1'b0;
  logic              out_reg_select_o;
  logic [3:0]        out_nibble_o;
  logic [WAIT_W-1:0] out_wait_before_us_o;
  logic [WAIT_W-1:0] out_wait_after_us_o;
  logic              out_last_o;

  char_lcd_nibble_sequencer_unit i_dut (.*);

  // Bench copy of the configuration registers.
  logic [WAIT_W-1:0] lcd_short_us   = RST_SHORT_SETTLE;
  logic [WAIT_W-1:0] lcd_long_us    = RST_LONG_SETTLE;
  logic [WAIT_W-1:0] lcd_powerup_us = RST_POWERUP_WAIT;

  lcd_word_t expected_words[$];
  int        mismatch_cnt = 0;
  int        word_cnt     = 0;
  logic      calm         = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("tb_char_lcd_nibble_sequencer_unit: errors");
    $finish;
  end

  task automatic report_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_LIMIT) $display("%0t ERROR %s", $time, msg);
  endtask

  function automatic logic [WAIT_W-1:0] sat_add16(logic [WAIT_W-1:0] a, logic [WAIT_W-1:0] b);
    logic [WAIT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[WAIT_W] ? WAIT_MAX : sum[WAIT_W-1:0];
  endfunction

  function automatic void queue_word(logic rs, logic [3:0] nib, logic [WAIT_W-1:0] pre_us,
                                     logic [WAIT_W-1:0] after, logic last);
    lcd_word_t w;
    w.rs       = rs;
    w.nib      = nib;
    w.wait_pre = pre_us;
    w.after    = after;
    w.last     = last;
    expected_words.push_back(w);
  endfunction

  // Clear and home on the command register get the long settle.
  function automatic void queue_byte(logic rs, logic [7:0] b, logic [WAIT_W-1:0] extra,
                                     logic last);
    logic [WAIT_W-1:0] settle;
    settle = (!rs && (b == CLEAR_DISPLAY || b == LCD_HOME)) ? lcd_long_us : lcd_short_us;
    queue_word(rs, b[7:4], '0, '0, 1'b0);
    queue_word(rs, b[3:0], '0, sat_add16(settle, extra), last);
  endfunction

  function automatic void expand_request(cmd_e cmd, logic [7:0] bval, logic row,
                                         logic [5:0] col);
    case (cmd)
      CMD_COMMAND: queue_byte(1'b0, bval, '0, 1'b1);
      CMD_DATA:    queue_byte(1'b1, bval, '0, 1'b1);
      CMD_CURSOR:  queue_byte(1'b0, (row ? CURSOR_BASE_ROW1 : CURSOR_BASE_ROW0) + {2'b00, col},
                              '0, 1'b1);
      default: begin
        queue_word(1'b0, WAKE_NIBBLE, lcd_powerup_us, INIT_WAIT_FIRST, 1'b0);
        queue_word(1'b0, WAKE_NIBBLE, '0, INIT_WAIT_SECOND, 1'b0);
        queue_word(1'b0, WAKE_NIBBLE, '0, '0, 1'b0);
        queue_word(1'b0, FOUR_BIT_NIBBLE, '0, '0, 1'b0);
        queue_byte(1'b0, FUNCTION_SET, '0, 1'b0);
        queue_byte(1'b0, DISPLAY_ON, '0, 1'b0);
        queue_byte(1'b0, ENTRY_MODE, '0, 1'b0);
        queue_byte(1'b0, CLEAR_DISPLAY, INIT_FINAL_EXTRA, 1'b1);
      end
    endcase
  endfunction

  // Returns at the edge that accepts the request; valid stays high for the caller.
  task automatic send_request(cmd_e cmd, logic [7:0] bval, logic row, logic [5:0] col);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_cmd_i        <= cmd;
    in_byte_value_i <= bval;
    in_row_i        <= row;
    in_col_i        <= col;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_random_request();
    cmd_e       cmd;
    logic [7:0] bval;
    logic       row;
    logic [5:0] col;
    int         pick;
    pick = $urandom_range(0, 9);
    cmd  = (pick < 3) ? CMD_COMMAND : (pick < 6) ? CMD_DATA : (pick < 8) ? CMD_CURSOR : CMD_INIT;
    if ($urandom_range(0, 3) == 0) bval = $urandom_range(0, 1) ? CLEAR_DISPLAY : LCD_HOME;
    else bval = 8'($urandom);
    row = 1'($urandom);
    // Mostly visible columns, now and then past the end of a row.
    col = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(40, 63)) : 6'($urandom_range(0, 39));
    send_request(cmd, bval, row, col);
    expand_request(cmd, bval, row, col);
  endtask

  task automatic put_register(cfg_idx_e idx, logic [WAIT_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      // The pulse width shows up in no word.
      CFG_ENABLE_PULSE: ;
      CFG_SHORT_SETTLE: lcd_short_us   = value;
      CFG_LONG_SETTLE:  lcd_long_us    = value;
      CFG_POWERUP_WAIT: lcd_powerup_us = value;
      default: ;
    endcase
  endtask

  task automatic write_config(logic [WAIT_W-1:0] pulse, logic [WAIT_W-1:0] short_us,
                              logic [WAIT_W-1:0] long_us, logic [WAIT_W-1:0] powerup);
    put_register(CFG_ENABLE_PULSE, pulse);
    put_register(CFG_SHORT_SETTLE, short_us);
    put_register(CFG_LONG_SETTLE, long_us);
    put_register(CFG_POWERUP_WAIT, powerup);
    cfg_we_i <= 1'b0;
  endtask

  // Drain every expected word, then let the back end settle.
  task automatic wait_idle();
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    dir_row_t drow;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      drow = DIRECTED[i];
      send_request(drow.cmd, drow.bval, drow.lcd_row, drow.lcd_col);
      if (drow.typed) begin
        queue_word(drow.t_rs, drow.t_hi, '0, '0, 1'b0);
        queue_word(drow.t_rs, drow.t_lo, '0, drow.t_settle, 1'b1);
      end else begin
        expand_request(drow.cmd, drow.bval, drow.lcd_row, drow.lcd_col);
      end
    end
    in_valid_i <= 1'b0;

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: write_config(16'd1, 16'd0, 16'd0, 16'd0);
        1: write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // Init clear lands exactly on the ceiling, then one past it.
        2: write_config(16'd0, 16'd1, 16'd63535, 16'd1);
        3: write_config(16'd50, 16'd50, 16'd63536, 16'd20000);
        default: write_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      if (ph == RANDOM_PHASES - 1) calm = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random_request();
      in_valid_i <= 1'b0;
    end

    wait_idle();
    if (expected_words.size() != 0)
      report_mismatch($sformatf("%0d words never arrived", expected_words.size()));
    if (mismatch_cnt == 0) begin
      $display("tb_char_lcd_nibble_sequencer_unit: clean");
    end else begin
      $display("tb_char_lcd_nibble_sequencer_unit: errors");
    end
    $finish;
  end

  // Receiver stalls in bursts, with free-running stretches between them.
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_stall_i <= 1'b0;
        repeat ($urandom_range(0, 20)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    lcd_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      word_cnt++;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("word %0d unexpected: rs=%0b nib=%h pre=%0d post=%0d last=%0b",
                                  word_cnt, out_reg_select_o, out_nibble_o,
                                  out_wait_before_us_o, out_wait_after_us_o, out_last_o));
      end else begin
        want = expected_words.pop_front();
        if (out_reg_select_o !== want.rs)
          report_mismatch($sformatf("word %0d reg_select %0b, want %0b",
                                    word_cnt, out_reg_select_o, want.rs));
        if (out_nibble_o !== want.nib)
          report_mismatch($sformatf("word %0d nibble %h, want %h",
                                    word_cnt, out_nibble_o, want.nib));
        if (out_wait_before_us_o !== want.wait_pre)
          report_mismatch($sformatf("word %0d wait_before %0d, want %0d",
                                    word_cnt, out_wait_before_us_o, want.wait_pre));
        if (out_wait_after_us_o !== want.after)
          report_mismatch($sformatf("word %0d wait_after %0d, want %0d",
                                    word_cnt, out_wait_after_us_o, want.after));
        if (out_last_o !== want.last)
          report_mismatch($sformatf("word %0d last %0b, want %0b",
                                    word_cnt, out_last_o, want.last));
      end
    end
  end

endmodule

/* sim.f */
sv/clns_pkg.sv
sv/clns_front.sv
sv/clns_back.sv
sv/char_lcd_nibble_sequencer_unit.sv
sv/clns_checker.sv
tb/tb_char_lcd_nibble_sequencer_unit.sv
